// ===== rtl/tmacs_pkg.sv =====
// Shared widths, constants and types of the trimmed-mean channel scanner.
// Used by the channel interfaces and by every module of the block.
package tmacs_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int CHANNEL_W = 3;
  localparam int VOLTS_W   = 11;

  // Sum of up to five 8-bit samples.
  localparam int SUM_W = 11;

  // Average times the scale factor: 255 * 400 stays below 2**17.
  localparam int PROD_W = 17;

  localparam int DEF_SAMPLES_PER_GROUP = 5;
  localparam int DEF_CHANNELS          = 8;

  // Hundredths of a volt: 4 * (100 * avg) / 51.
  localparam int SCALE_MUL = 4 * 100;
  localparam int SCALE_DIV = 51;

  // Fraction bits of the reciprocals used for division by a constant.
  localparam int RECIP_SHIFT = 20;

  // Running extremes and sum handed from cell to cell.
  typedef struct packed {
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [SUM_W-1:0]    sum;
  } red_t;

endpackage

// ===== rtl/tmacs_if.sv =====
// Valid/ready channel interfaces of the trimmed-mean channel scanner.
// Depends on tmacs_pkg for the payload widths.
interface tmacs_sample_if import tmacs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface tmacs_result_if import tmacs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHANNEL_W-1:0] channel;
  logic [VOLTS_W-1:0]   volts_hundredths;

  modport source (output valid, output channel, output volts_hundredths, input ready);
  modport sink   (input valid, input channel, input volts_hundredths, output ready);
endinterface

// ===== rtl/tmacs_cell.sv =====
// One cell of the sample chain: holds a sample, passes it on, and folds it
// into the running minimum, maximum and sum. Depends on tmacs_pkg.
module tmacs_cell import tmacs_pkg::*; (
  input  logic                clk,
  input  logic                shift_en,
  input  logic [SAMPLE_W-1:0] samp_in,
  input  red_t                red_in,
  output logic [SAMPLE_W-1:0] samp_out,
  output red_t                red_out
);

  logic [SAMPLE_W-1:0] samp;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      samp <= samp_in;
    end
  end

  always_comb begin
    red_out.lo  = (samp < red_in.lo) ? samp : red_in.lo;
    red_out.hi  = (samp > red_in.hi) ? samp : red_in.hi;
    red_out.sum = red_in.sum + SUM_W'(samp);
  end

  assign samp_out = samp;

endmodule

// ===== rtl/tmacs_cdiv.sv =====
// Two-stage division by a constant: reciprocal multiply, then one
// compare-and-subtract correction. Depends on tmacs_pkg.
module tmacs_cdiv import tmacs_pkg::*; #(
  parameter int W       = SUM_W,
  parameter int DIVISOR = 3
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [W-1:0] in_value,
  output logic         out_valid,
  output logic [W-1:0] out_value
);

  localparam int M_W = RECIP_SHIFT + 1;
  localparam logic [M_W-1:0] RECIP = M_W'((64'd1 << RECIP_SHIFT) / DIVISOR);
  localparam logic [W-1:0]   DIV_W = W'(DIVISOR);

  logic             v1;
  logic [W-1:0]     x1;
  logic [W-1:0]     q1;
  logic [W+M_W-1:0] full;
  logic [W-1:0]     prod;
  logic [W-1:0]     rem;

  // The truncated reciprocal makes the first quotient at most one too small.
  assign full = (W+M_W)'(in_value) * (W+M_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    x1        <= in_value;
    q1        <= full[RECIP_SHIFT +: W];
    out_value <= (rem >= DIV_W) ? q1 + W'(1) : q1;
  end

  assign prod = q1 * DIV_W;
  assign rem  = x1 - prod;

endmodule

// ===== rtl/trimmed_mean_adc_channel_scan_core.sv =====
// Top level of the trimmed-mean channel scanner: sample chain, channel
// sequencing and scaling pipeline. Depends on tmacs_pkg, tmacs_if,
// tmacs_cell and tmacs_cdiv.
//
// The block takes one 8-bit converter sample per request and collects
// SAMPLES_PER_GROUP samples for the current channel, starting at channel 0.
// When a group completes, the smallest and largest sample are dropped, the
// rest are averaged (truncating) and scaled to hundredths of a volt as
// 4*(100*avg)/51, and one result carrying the channel and the value is
// emitted; the channel then advances round-robin, wrapping from CHANNELS-1 to
// 0. A sample is taken every cycle unless stalled as described below. The
// request that completes a group starts the result pipeline (trim register,
// two divide-by-constant stages, scale multiply, two divide-by-51 stages,
// output register). Samples of the next group keep flowing meanwhile; only
// the next group-completing sample waits until the previous result has been
// taken, since a single result is in flight at a time.
module trimmed_mean_adc_channel_scan_core import tmacs_pkg::*; #(
  parameter int SAMPLES_PER_GROUP = DEF_SAMPLES_PER_GROUP,
  parameter int CHANNELS          = DEF_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst,
  tmacs_sample_if.sink          samples,
  tmacs_result_if.source        results
);

  localparam int CNT_W  = $clog2(SAMPLES_PER_GROUP);
  localparam int CELLS  = SAMPLES_PER_GROUP - 1;
  localparam int KEPT   = SAMPLES_PER_GROUP - 2;

  localparam logic [CNT_W-1:0]     LAST_SLOT = CNT_W'(SAMPLES_PER_GROUP - 1);
  localparam logic [CHANNEL_W-1:0] LAST_CHAN = CHANNEL_W'(CHANNELS - 1);

  // Group bookkeeping.
  logic [CNT_W-1:0]     count;
  logic [CHANNEL_W-1:0] cur_chan;
  logic [CHANNEL_W-1:0] chan_hold;
  logic                 busy;
  logic                 last;
  logic                 take;
  logic                 done;

  // Sample chain. The incoming sample heads the reduction, so the chain
  // needs one cell fewer than the group size.
  logic [SAMPLE_W-1:0]  samp_link [CELLS+1];
  red_t                 red_link  [CELLS+1];

  // Result pipeline.
  logic                 t_valid;
  logic [SUM_W-1:0]     t_value;
  logic                 avg_valid;
  logic [SUM_W-1:0]     avg_value;
  logic                 p_valid;
  logic [PROD_W-1:0]    p_value;
  logic                 volts_valid;
  logic [PROD_W-1:0]    volts_value;
  logic [SUM_W-1:0]     trimmed;

  assign last = (count == LAST_SLOT);

  // A completing sample waits while the previous result is still in flight.
  assign samples.ready = !(last && busy);
  assign take          = samples.valid && samples.ready;
  assign done          = results.valid && results.ready;

  assign samp_link[0]    = samples.sample;
  assign red_link[0].lo  = samples.sample;
  assign red_link[0].hi  = samples.sample;
  assign red_link[0].sum = SUM_W'(samples.sample);

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    tmacs_cell u_cell (
      .clk      (clk),
      .shift_en (take),
      .samp_in  (samp_link[i]),
      .red_in   (red_link[i]),
      .samp_out (samp_link[i+1]),
      .red_out  (red_link[i+1])
    );
  end

  // Only one copy of each extreme is dropped, as when trimming a sorted group.
  assign trimmed = red_link[CELLS].sum - SUM_W'(red_link[CELLS].lo)
                   - SUM_W'(red_link[CELLS].hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      cur_chan <= '0;
      busy     <= 1'b0;
    end else begin
      if (take) begin
        if (last) begin
          count    <= '0;
          cur_chan <= (cur_chan >= LAST_CHAN) ? '0 : cur_chan + CHANNEL_W'(1);
        end else begin
          count <= count + CNT_W'(1);
        end
      end
      if (take && last) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && last) begin
      chan_hold <= cur_chan;
      t_value   <= trimmed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      t_valid <= take && last;
      p_valid <= avg_valid;
    end
  end

  tmacs_cdiv #(
    .W       (SUM_W),
    .DIVISOR (KEPT)
  ) u_avg_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (t_valid),
    .in_value  (t_value),
    .out_valid (avg_valid),
    .out_value (avg_value)
  );

  // The average of 8-bit samples fits in 8 bits.
  always_ff @(posedge clk) begin
    p_value <= PROD_W'(avg_value[SAMPLE_W-1:0]) * PROD_W'(SCALE_MUL);
  end

  tmacs_cdiv #(
    .W       (PROD_W),
    .DIVISOR (SCALE_DIV)
  ) u_scale_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_valid),
    .in_value  (p_value),
    .out_valid (volts_valid),
    .out_value (volts_value)
  );

  // Output register; it is always empty when a new result arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (volts_valid) begin
      results.valid <= 1'b1;
    end else if (done) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (volts_valid) begin
      results.channel          <= chan_hold;
      results.volts_hundredths <= volts_value[VOLTS_W-1:0];
    end
  end

  // At most one group is anywhere in the result pipeline.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $onehot0({t_valid, avg_valid, p_valid, volts_valid, results.valid}))
    else $error("more than one result in flight");

  // A completing sample always marks the block busy.
  a_busy_after_group: assert property (@(posedge clk) disable iff (rst)
    (take && last) |=> busy)
    else $error("group completed without entering busy");

  // While a result is in flight the block stays busy.
  a_busy_covers: assert property (@(posedge clk) disable iff (rst)
    (t_valid || avg_valid || p_valid || volts_valid || results.valid) |-> busy)
    else $error("result in flight while not busy");

  // The scaled value never exceeds 20.00 V.
  a_volts_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.volts_hundredths <= VOLTS_W'(2000)))
    else $error("scaled value out of range");

  // The reported channel lies within the scanned channels.
  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.channel <= LAST_CHAN))
    else $error("channel out of range");

endmodule

// ===== tb/sv/tb_trimmed_mean_adc_channel_scan_core.sv =====
// Self-checking testbench of the trimmed-mean channel scanner.
// Depends on tmacs_pkg, tmacs_if and the trimmed_mean_adc_channel_scan_core RTL.
`timescale 1ns / 1ps

module tb_trimmed_mean_adc_channel_scan_core;
  import tmacs_pkg::*;

  localparam int GROUP_LEN      = DEF_SAMPLES_PER_GROUP;
  localparam int CHANNEL_COUNT  = DEF_CHANNELS;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
  localparam int RANDOM_SAMPLES = 1070;
  localparam int BURST_GROUPS   = 8;
  // Timeout for the whole run, set well above what a correct run needs.
  localparam int CYCLE_LIMIT    = 200000;
  // Covers the result pipeline latency, with margin.
  localparam int SETTLE_CYCLES  = 16;

  typedef logic [SAMPLE_W-1:0] group_t [GROUP_LEN];

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [VOLTS_W-1:0]   volts;
  } reading_t;

  // Shapes of random sample groups.
  typedef enum int {
    MIX_UNIFORM,
    MIX_LOW_RAIL,
    MIX_HIGH_RAIL,
    MIX_TWO_LEVEL,
    MIX_FLAT
  } group_mix_t;

  logic clk;
  logic rst;

  tmacs_sample_if sample_ch ();
  tmacs_result_if result_ch ();

  trimmed_mean_adc_channel_scan_core u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch)
  );

  // Mirror of the block's state: the group being collected, how many samples it
  // holds, and the channel it belongs to.
  logic [SAMPLE_W-1:0]  group_buf [GROUP_LEN];
  int unsigned          group_fill;
  logic [CHANNEL_W-1:0] scan_channel;

  // Readings that the block owes us, oldest first.
  reading_t pending_readings [$];

  int          fault_count;
  int          samples_sent;
  int          readings_seen;
  int          cycle_count;
  int unsigned ready_hold;
  // While set, neither side inserts idle cycles.
  bit          steady_flow;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Trimmed mean of the collected group in hundredths of a volt. Dropping one
  // copy of the minimum and one of the maximum is the same as removing the ends
  // of the sorted group, so ties need no special handling.
  function automatic logic [VOLTS_W-1:0] trimmed_volts();
    int unsigned total;
    int unsigned lo;
    int unsigned hi;
    int unsigned avg;
    int          k;
    total = 0;
    lo    = SAMPLE_MAX;
    hi    = 0;
    for (k = 0; k < GROUP_LEN; k++) begin
      total += group_buf[k];
      if (group_buf[k] < lo) lo = group_buf[k];
      if (group_buf[k] > hi) hi = group_buf[k];
    end
    avg = (total - lo - hi) / (GROUP_LEN - 2);
    return VOLTS_W'((SCALE_MUL * avg) / SCALE_DIV);
  endfunction

  // Advance the mirrored state by one accepted sample; a completed group
  // queues one reading and moves the scan on to the next channel.
  function automatic void absorb_sample(logic [SAMPLE_W-1:0] s);
    reading_t r;
    group_buf[group_fill] = s;
    group_fill++;
    if (group_fill == GROUP_LEN) begin
      r.channel = scan_channel;
      r.volts   = trimmed_volts();
      pending_readings.push_back(r);
      group_fill   = 0;
      scan_channel = (scan_channel == CHANNEL_COUNT - 1) ? '0 : scan_channel + 1'b1;
    end
  endfunction

  function automatic void check_reading(logic [CHANNEL_W-1:0] ch, logic [VOLTS_W-1:0] v);
    reading_t want;
    readings_seen++;
    if (pending_readings.size() == 0) begin
      $error("unexpected reading: channel %0d volts_hundredths %0d", ch, v);
      fault_count++;
      return;
    end
    want = pending_readings.pop_front();
    if (ch !== want.channel) begin
      $error("channel mismatch: expected %0d, actual %0d", want.channel, ch);
      fault_count++;
    end
    if (v !== want.volts) begin
      $error("volts_hundredths mismatch: expected %0d, actual %0d", want.volts, v);
      fault_count++;
    end
  endfunction

  // Result side: check every taken reading, then hold ready low for a random
  // number of cycles before the next one.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        check_reading(result_ch.channel, result_ch.volts_hundredths);
        ready_hold = steady_flow ? 0 : $urandom_range(0, 3);
      end
      if (ready_hold > 0) begin
        result_ch.ready <= 1'b0;
        ready_hold--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Guard against a hung handshake anywhere in the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("trimmed_mean_adc_channel_scan_core verification failed");
      $finish;
    end
  end

  // Offer one sample after a random gap and wait until the request is taken.
  // The valid line is only lowered during a gap, so back-to-back requests keep
  // it high without a second assignment in the same step.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    absorb_sample(s);
    samples_sent++;
  endtask

  task automatic send_group(input group_t g);
    int k;
    for (k = 0; k < GROUP_LEN; k++) send_sample(g[k]);
  endtask

  // Stop offering samples until every owed reading has been taken. At least
  // one edge passes, so the lowered valid line is seen before the next request.
  task automatic drain_readings();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  function automatic group_t random_group(group_mix_t mix);
    group_t               g;
    logic [SAMPLE_W-1:0]  a;
    logic [SAMPLE_W-1:0]  b;
    int                   k;
    a = $urandom_range(0, SAMPLE_MAX);
    b = $urandom_range(0, SAMPLE_MAX);
    for (k = 0; k < GROUP_LEN; k++) begin
      case (mix)
        MIX_LOW_RAIL:  g[k] = $urandom_range(0, 7);
        MIX_HIGH_RAIL: g[k] = $urandom_range(SAMPLE_MAX - 7, SAMPLE_MAX);
        MIX_TWO_LEVEL: g[k] = $urandom_range(0, 1) ? a : b;
        MIX_FLAT:      g[k] = a;
        default:       g[k] = $urandom_range(0, SAMPLE_MAX);
      endcase
    end
    return g;
  endfunction

  // Full-scale ends: all zeros must read 0 and all ones must read 20.00 V.
  task automatic test_rail_levels();
    send_group('{default: 8'h00});
    send_group('{default: 8'hFF});
  endtask

  // Several samples share the minimum and the maximum; only one copy of each
  // may be dropped. A flat group is the extreme form of the same case.
  task automatic test_tied_extremes();
    send_group('{8'd10, 8'd200, 8'd10, 8'd200, 8'd50});
    send_group('{default: 8'd128});
  endtask

  // Alternating bit patterns toggle every sample bit in both directions.
  task automatic test_bit_patterns();
    send_group('{8'hAA, 8'h55, 8'hFF, 8'h00, 8'h5A});
  endtask

  // Pause in the middle of a group with the result pipeline emptied, then
  // finish the group; the partial group must survive the pause.
  task automatic test_mid_group_pause();
    group_t g;
    int     k;
    g = random_group(MIX_UNIFORM);
    for (k = 0; k < 2; k++) send_sample(g[k]);
    drain_readings();
    for (k = 2; k < GROUP_LEN; k++) send_sample(g[k]);
  endtask

  // Requests and results with no idle cycles at all, so consecutive groups
  // run into the single-result limit of the output pipeline.
  task automatic test_steady_stream();
    int g;
    steady_flow = 1'b1;
    for (g = 0; g < BURST_GROUPS; g++) send_group(random_group(MIX_UNIFORM));
    steady_flow = 1'b0;
  endtask

  // Bulk random groups of mixed shapes, with short idle-free stretches and an
  // occasional full drain between groups.
  task automatic test_random_groups();
    int         target;
    int         g;
    group_mix_t mix;
    target = samples_sent + RANDOM_SAMPLES;
    g = 0;
    while (samples_sent < target) begin
      steady_flow = ((g % 50) >= 44);
      if ($urandom_range(0, 5) > 3) mix = MIX_UNIFORM;
      else mix = group_mix_t'($urandom_range(MIX_LOW_RAIL, MIX_FLAT));
      send_group(random_group(mix));
      if ((g % 37) == 36) drain_readings();
      g++;
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst              <= 1'b1;
    sample_ch.valid  <= 1'b0;
    sample_ch.sample <= '0;
    steady_flow   = 1'b0;
    fault_count   = 0;
    samples_sent  = 0;
    readings_seen = 0;
    cycle_count   = 0;
    group_fill    = 0;
    scan_channel  = '0;
    foreach (group_buf[k]) group_buf[k] = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_rail_levels();
    test_tied_extremes();
    test_bit_patterns();
    test_mid_group_pause();
    test_steady_stream();
    test_random_groups();

    // Let the last readings come out, then watch a while for stray ones.
    sample_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d samples and checked %0d channel readings (%0d full scans).",
             samples_sent, readings_seen, readings_seen / CHANNEL_COUNT);
    $display("Covered rail levels, tied extremes, mid-group pauses and idle-free bursts.");
    if (fault_count == 0) begin
      $display("trimmed_mean_adc_channel_scan_core verification clean");
    end else begin
      $display("trimmed_mean_adc_channel_scan_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tmacs_pkg.sv
rtl/tmacs_if.sv
rtl/tmacs_cell.sv
rtl/tmacs_cdiv.sv
rtl/trimmed_mean_adc_channel_scan_core.sv
tb/sv/tb_trimmed_mean_adc_channel_scan_core.sv
